// ===== rtl/ttc_pkg.sv =====
// Shared types and constants for the triangle tangent unit.
// No dependencies; imported by every other file of the block.
package ttc_pkg;

	localparam int DP_W   = 33;	// position delta
	localparam int DUV_W  = 25;	// uv delta
	localparam int PROD_W = DP_W + DUV_W;	// one product
	localparam int NUM_W  = PROD_W + 1;	// numerator
	localparam int DET_W  = 2 * DUV_W + 1;	// uv determinant
	localparam int QUO_W  = 33;	// quotient bits produced by the divider
	localparam int MUL_STEPS = 7;	// det, three vtan and three utan numerators
	localparam int LANES  = 6;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_DET_ZERO = 2'd1;
	localparam logic [1:0] ST_SAT      = 2'd2;
	localparam logic [1:0] ST_NOT_TRI  = 2'd3;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [23:0] tex_u;
		logic signed [23:0] tex_v;
		logic               last_vertex;
	} vtx_item_t;

	typedef struct packed {
		logic signed [31:0] vtan_x;
		logic signed [31:0] vtan_y;
		logic signed [31:0] vtan_z;
		logic signed [31:0] utan_x;
		logic signed [31:0] utan_y;
		logic signed [31:0] utan_z;
		logic [1:0]         status;
		logic               last_triangle;
	} tan_item_t;

	typedef struct packed {
		logic       load_v0;
		logic       load_v1;
		logic       load_v2;
		logic       mul_en;
		logic [2:0] mul_sel;
		logic       div_init;
		logic       div_step;
		logic       finish;
		logic       early_end;
	} ttc_cmd_t;

endpackage

// ===== rtl/ttc_datapath.sv =====
// Datapath of the triangle tangent unit: vertex holding registers, shared
// multiplier pair, six bit-serial dividers and the result register. Uses ttc_pkg.
module ttc_datapath (
	input  logic                clk,
	input  ttc_pkg::ttc_cmd_t   cmd,
	input  ttc_pkg::vtx_item_t  vtx,
	output ttc_pkg::tan_item_t  tan
);
	import ttc_pkg::*;

	logic signed [31:0]       hp0_q [3];
	logic signed [31:0]       hp1_q [3];
	logic signed [23:0]       huv0_q [2];
	logic signed [23:0]       huv1_q [2];
	logic signed [31:0]       pin [3];
	logic signed [DP_W-1:0]   dp1_q [3];
	logic signed [DP_W-1:0]   dp2_q [3];
	logic signed [DUV_W-1:0]  du1_q, dv1_q, du2_q, dv2_q;
	logic                     last_q;

	logic signed [DP_W-1:0]   ma, mc;
	logic signed [DUV_W-1:0]  mb, md;
	logic [1:0]               kk;
	logic signed [PROD_W-1:0] prod_a_s1, prod_b_s1;
	logic                     mul_v_s1;
	logic [2:0]               sel_s1;
	logic [2:0]               nidx;
	logic [NUM_W-1:0]         diff;
	logic [DET_W-1:0]         det_q;
	logic [NUM_W-1:0]         num_q [LANES];

	logic [DET_W-1:0]         ad_c, ad_q;
	logic                     det_zero_q;
	logic [NUM_W-1:0]         an_c [LANES];
	logic [DET_W-1:0]         r_q [LANES];
	logic [QUO_W-1:0]         sh_q [LANES];
	logic [QUO_W-1:0]         q_q [LANES];
	logic                     neg_q [LANES];
	logic                     ovf_q [LANES];
	logic [DET_W:0]           r2 [LANES];
	logic                     ge [LANES];
	logic [DET_W:0]           rsub [LANES];
	logic [QUO_W-1:0]         lim [LANES];
	logic                     sat [LANES];
	logic [QUO_W-1:0]         mag [LANES];
	logic [31:0]              res [LANES];
	logic                     sat_any;

	assign pin[0] = vtx.pos_x;
	assign pin[1] = vtx.pos_y;
	assign pin[2] = vtx.pos_z;

	// vertex capture and deltas
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (cmd.load_v0) hp0_q[k] <= pin[k];
			if (cmd.load_v1) hp1_q[k] <= pin[k];
			if (cmd.load_v2) begin
				dp1_q[k] <= {hp1_q[k][31], hp1_q[k]} - {hp0_q[k][31], hp0_q[k]};
				dp2_q[k] <= {pin[k][31], pin[k]} - {hp0_q[k][31], hp0_q[k]};
			end
		end
		if (cmd.load_v0) begin
			huv0_q[0] <= vtx.tex_u;
			huv0_q[1] <= vtx.tex_v;
		end
		if (cmd.load_v1) begin
			huv1_q[0] <= vtx.tex_u;
			huv1_q[1] <= vtx.tex_v;
		end
		if (cmd.load_v2) begin
			du1_q  <= {huv1_q[0][23], huv1_q[0]} - {huv0_q[0][23], huv0_q[0]};
			dv1_q  <= {huv1_q[1][23], huv1_q[1]} - {huv0_q[1][23], huv0_q[1]};
			du2_q  <= {vtx.tex_u[23], vtx.tex_u} - {huv0_q[0][23], huv0_q[0]};
			dv2_q  <= {vtx.tex_v[23], vtx.tex_v} - {huv0_q[1][23], huv0_q[1]};
			last_q <= vtx.last_vertex;
		end
	end

	// operand select: step 0 det, 1..3 vtan numerators, 4..6 utan numerators
	always_comb begin
		kk = 2'd0;
		ma = '0;
		mb = '0;
		mc = '0;
		md = '0;
		unique case (cmd.mul_sel)
			3'd0: begin
				ma = {{(DP_W-DUV_W){du1_q[DUV_W-1]}}, du1_q};
				mb = dv2_q;
				mc = {{(DP_W-DUV_W){dv1_q[DUV_W-1]}}, dv1_q};
				md = du2_q;
			end
			3'd1, 3'd2, 3'd3: begin
				kk = 2'(cmd.mul_sel - 3'd1);
				ma = dp2_q[kk];
				mb = du1_q;
				mc = dp1_q[kk];
				md = du2_q;
			end
			3'd4, 3'd5, 3'd6: begin
				kk = 2'(cmd.mul_sel - 3'd4);
				ma = dp1_q[kk];
				mb = dv2_q;
				mc = dp2_q[kk];
				md = dv1_q;
			end
			default: begin
				kk = 2'd0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_a_s1 <= ma * mb;
		prod_b_s1 <= mc * md;
		sel_s1    <= cmd.mul_sel;
		mul_v_s1  <= cmd.mul_en;
	end

	assign diff = {prod_a_s1[PROD_W-1], prod_a_s1} - {prod_b_s1[PROD_W-1], prod_b_s1};
	assign nidx = sel_s1 - 3'd1;

	always_ff @(posedge clk) begin
		if (mul_v_s1) begin
			if (sel_s1 == 3'd0) det_q <= diff[DET_W-1:0];
			else num_q[nidx] <= diff;
		end
	end

	assign ad_c = det_q[DET_W-1] ? (~det_q + 1'b1) : det_q;

	// restoring division, one quotient bit per lane per cycle, then saturation and sign
	always_comb begin
		sat_any = 1'b0;
		for (int i = 0; i < LANES; i++) begin
			an_c[i] = num_q[i][NUM_W-1] ? (~num_q[i] + 1'b1) : num_q[i];
			r2[i]   = {r_q[i], sh_q[i][QUO_W-1]};
			ge[i]   = r2[i] >= {1'b0, ad_q};
			rsub[i] = r2[i] - {1'b0, ad_q};
			lim[i]  = neg_q[i] ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
			sat[i]  = ovf_q[i] || (q_q[i] > lim[i]);
			mag[i]  = sat[i] ? lim[i] : q_q[i];
			res[i]  = neg_q[i] ? (~mag[i][31:0] + 32'd1) : mag[i][31:0];
			sat_any = sat_any | sat[i];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			ad_q       <= ad_c;
			det_zero_q <= (det_q == '0);
			for (int i = 0; i < LANES; i++) begin
				neg_q[i] <= num_q[i][NUM_W-1] ^ det_q[DET_W-1];
				ovf_q[i] <= {9'd0, an_c[i][NUM_W-1:17]} >= ad_c;
				r_q[i]   <= {9'd0, an_c[i][NUM_W-1:17]};
				sh_q[i]  <= {an_c[i][16:0], 16'd0};
				q_q[i]   <= '0;
			end
		end else if (cmd.div_step) begin
			for (int i = 0; i < LANES; i++) begin
				r_q[i]  <= ge[i] ? rsub[i][DET_W-1:0] : r2[i][DET_W-1:0];
				sh_q[i] <= {sh_q[i][QUO_W-2:0], 1'b0};
				q_q[i]  <= {q_q[i][QUO_W-2:0], ge[i]};
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.early_end) begin
			tan <= '{status: ST_NOT_TRI, last_triangle: 1'b1, default: '0};
		end else if (cmd.finish) begin
			if (det_zero_q) begin
				tan <= '{status: ST_DET_ZERO, last_triangle: last_q, default: '0};
			end else begin
				tan <= '{vtan_x: res[0], vtan_y: res[1], vtan_z: res[2],
					utan_x: res[3], utan_y: res[4], utan_z: res[5],
					status: (sat_any ? ST_SAT : ST_OK), last_triangle: last_q};
			end
		end
	end

endmodule

// ===== rtl/ttc_ctrl.sv =====
// Controller of the triangle tangent unit: vertex phase, step sequencer and
// result valid. Uses ttc_pkg; drives ttc_datapath through ttc_cmd_t.
module ttc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vtx_valid,
	input  logic               vtx_last,
	output logic               vtx_stall,
	output logic               tan_valid,
	input  logic               tan_stall,
	output ttc_pkg::ttc_cmd_t  cmd
);
	import ttc_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_MUL, S_DRAIN, S_DINIT, S_DIV, S_FIN
	} state_t;

	state_t     state_q;
	logic [1:0] phase_q;
	logic [5:0] cnt_q;
	logic       acc;
	logic       out_free;

	assign vtx_stall = (state_q != S_IDLE) || (tan_valid && tan_stall);
	assign acc       = vtx_valid && !vtx_stall;
	assign out_free  = !tan_valid || !tan_stall;

	always_comb begin
		cmd           = '0;
		cmd.load_v0   = acc && (phase_q == 2'd0) && !vtx_last;
		cmd.load_v1   = acc && (phase_q == 2'd1) && !vtx_last;
		cmd.load_v2   = acc && (phase_q == 2'd2);
		cmd.early_end = acc && (phase_q != 2'd2) && vtx_last;
		cmd.mul_en    = (state_q == S_MUL);
		cmd.mul_sel   = cnt_q[2:0];
		cmd.div_init  = (state_q == S_DINIT);
		cmd.div_step  = (state_q == S_DIV);
		cmd.finish    = (state_q == S_FIN) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			phase_q   <= 2'd0;
			cnt_q     <= '0;
			tan_valid <= 1'b0;
		end else begin
			if (cmd.early_end || cmd.finish) tan_valid <= 1'b1;
			else if (tan_valid && !tan_stall) tan_valid <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (cmd.load_v2) begin
						state_q <= S_MUL;
						cnt_q   <= '0;
						phase_q <= 2'd0;
					end else if (cmd.early_end) begin
						phase_q <= 2'd0;
					end else if (acc) begin
						phase_q <= phase_q + 2'd1;
					end
				end
				S_MUL: begin
					if (cnt_q == 6'(MUL_STEPS - 1)) state_q <= S_DRAIN;
					else cnt_q <= cnt_q + 6'd1;
				end
				S_DRAIN: begin
					state_q <= S_DINIT;
				end
				S_DINIT: begin
					state_q <= S_DIV;
					cnt_q   <= '0;
				end
				S_DIV: begin
					if (cnt_q == 6'(QUO_W - 1)) state_q <= S_FIN;
					else cnt_q <= cnt_q + 6'd1;
				end
				S_FIN: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/triangle_tangent_calc.sv =====
// Triangle tangent unit: groups vertices in threes, emits vtan/utan per triangle.
// First and second vertex of a triangle: one per clock unless a stalled result holds input.
// Third vertex: after its transfer come 7 multiply steps on a shared multiplier
// pair, drain, divider setup, 33 quotient bits and finish, then result valid.
// An end marker on a first or second vertex gives a result the next cycle.
// Async active-low reset clears phase, sequencer and result valid.
module triangle_tangent_calc (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                vtx_valid,
	output logic                vtx_stall,
	input  ttc_pkg::vtx_item_t  vtx,
	output logic                tan_valid,
	input  logic                tan_stall,
	output ttc_pkg::tan_item_t  tan
);
	import ttc_pkg::*;

	// command bundle from sequencer to datapath
	ttc_cmd_t cmd;

	// controller: accepts vertices only when idle and the result register
	// can take a new transfer
	ttc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.vtx_valid (vtx_valid),
		.vtx_last  (vtx.last_vertex),
		.vtx_stall (vtx_stall),
		.tan_valid (tan_valid),
		.tan_stall (tan_stall),
		.cmd       (cmd)
	);

	// datapath: holds vertices 0/1, forms det and numerators, six dividers
	ttc_datapath u_dp (
		.clk (clk),
		.cmd (cmd),
		.vtx (vtx),
		.tan (tan)
	);

endmodule

// ===== rtl/ttc_checker.sv =====
// Port-level checker for triangle_tangent_calc, attached by bind.
// Uses ttc_pkg for the item types and status codes.
module ttc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                vtx_valid,
	input logic                vtx_stall,
	input ttc_pkg::vtx_item_t  vtx,
	input logic                tan_valid,
	input logic                tan_stall,
	input ttc_pkg::tan_item_t  tan
);
	import ttc_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		tan_valid && tan_stall |=> tan_valid)
		else $error("result valid dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		tan_valid && tan_stall |=> $stable(tan))
		else $error("stalled result changed");

	a_not_tri_last: assert property (@(posedge clk) disable iff (!arst_n)
		tan_valid && (tan.status == ST_NOT_TRI) |-> tan.last_triangle)
		else $error("partial triangle result without end mark");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		tan_valid && ((tan.status == ST_NOT_TRI) || (tan.status == ST_DET_ZERO)) |->
		(tan.vtan_x == 0) && (tan.vtan_y == 0) && (tan.vtan_z == 0) &&
		(tan.utan_x == 0) && (tan.utan_y == 0) && (tan.utan_z == 0))
		else $error("tangent fields not zero on error status");

	a_early_end: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_valid && !vtx_stall && !vtx.last_vertex |=> !(tan_valid && $rose(tan_valid) &&
		(tan.status == ST_NOT_TRI)))
		else $error("partial triangle result without end marker");

endmodule

bind triangle_tangent_calc ttc_checker u_ttc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.vtx_valid (vtx_valid),
	.vtx_stall (vtx_stall),
	.vtx       (vtx),
	.tan_valid (tan_valid),
	.tan_stall (tan_stall),
	.tan       (tan)
);
